>>> hdl/lemq_pkg.sv
// ----------------------------------------------------------------------------
// lemq_pkg: shared types and constants for the line envelope block
// Table geometry, field widths, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lemq_pkg;

  // Table geometry.
  localparam int MAX_LINES = 64;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  // Field widths. Stored coefficients carry one extra bit for a negated -2^31.
  localparam int COEF_W  = 32;
  localparam int LINE_W  = COEF_W + 1;
  localparam int WORD_W  = 2 * LINE_W;
  localparam int DIFF_W  = LINE_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int VALUE_W = 64;
  localparam int STAT_W  = 2;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS_RD,
    ST_POS_CHK,
    ST_PREV_RD,
    ST_PREV_LD,
    ST_SUCC_CHK,
    ST_SUCC_RD0,
    ST_SUCC_RD1,
    ST_SUCC_LD,
    ST_PRED_CHK,
    ST_PRED_RD0,
    ST_PRED_RD1,
    ST_PRED_LD,
    ST_TST0,
    ST_TST1,
    ST_TST2,
    ST_SIZE,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_PUT,
    ST_Q_RD,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_DONE
  } state_t;

  // Which loop a dominance test returns to.
  typedef enum logic [1:0] {
    CTX_MID,
    CTX_SUCC,
    CTX_PRED
  } ctx_t;

endpackage

>>> hdl/lemq_if.sv
// ----------------------------------------------------------------------------
// lemq_if: valid/ready channels of the line envelope block
// Request, result and configuration channels, each with source and sink views.
// ----------------------------------------------------------------------------
interface lemq_in_if import lemq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [COEF_W-1:0] slope;
  logic signed [COEF_W-1:0] intercept;
  logic signed [COEF_W-1:0] x_point;

  modport source (output valid, req_type, slope, intercept, x_point, input ready);
  modport sink   (input valid, req_type, slope, intercept, x_point, output ready);
endinterface

interface lemq_out_if import lemq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [STAT_W-1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface lemq_cfg_if ();
  logic valid;
  logic ready;
  logic min_mode;

  modport source (output valid, min_mode, input ready);
  modport sink   (input valid, min_mode, output ready);
endinterface

>>> hdl/lemq_mul.sv
// ----------------------------------------------------------------------------
// lemq_mul: shared signed multiplier with a registered product
// Serves both the cross-multiplication tests and the query evaluation.
// ----------------------------------------------------------------------------
module lemq_mul import lemq_pkg::*; (
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] op_x,
  input  logic signed [DIFF_W-1:0] op_y,
  output logic signed [PROD_W-1:0] prod_r
);

  // One exact product per cycle.
  always_ff @(posedge clk) begin
    prod_r <= op_x * op_y;
  end

endmodule

>>> hdl/line_envelope_max_query.sv
// ----------------------------------------------------------------------------
// line_envelope_max_query: upper envelope of lines with max/min queries
// Sequenced insert with exact pruning and linear-scan query over a line table.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_LINES lines sorted by slope in a table with one
// read port and one write port and handles one request word at a time; it is
// not ready while a request is in progress. All arithmetic runs through one
// shared 34x34 multiplier. A query reads, multiplies and accumulates each kept
// line in turn. An insert searches the slope order line by line, tests the new
// line against the lines on both sides of the insertion point, runs a
// dominance test against each successor or predecessor (a loop check, two
// table reads, an operand load and the cross-multiplication), shifts entries
// in the table with one read and one write each and then commits. A result
// word may wait at the output while the next request is accepted. The user
// must see that min_mode is written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module line_envelope_max_query import lemq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lemq_in_if.sink       in_chan,
  lemq_out_if.source    out_chan,
  lemq_cfg_if.sink      cfg_chan
);

  // Line table.
  logic [WORD_W-1:0] mem [MAX_LINES];
  logic [WORD_W-1:0] rdata_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;

  state_t state_r, state_nxt;
  ctx_t   ctx_r;

  logic                      min_mode_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          pos_r, j_r, k1_r, ci_r, cnt_r, dst_r, newn_r;
  logic                      asc_r;
  logic signed [LINE_W-1:0]  na_r, nb_r;
  logic [WORD_W-1:0]         t1_r, t2_r, t3_r;
  logic signed [PROD_W-1:0]  p0_r;
  logic signed [COEF_W-1:0]  x_r;
  logic signed [VALUE_W-1:0] best_r;
  logic signed [VALUE_W-1:0] res_value_r;
  logic [STAT_W-1:0]         res_status_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [STAT_W-1:0]         out_status_r;

  logic signed [DIFF_W-1:0]  op_x, op_y;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      in_acc;
  logic                      out_load;
  logic signed [LINE_W-1:0]  rd_a, rd_b;
  logic signed [LINE_W-1:0]  t1a, t1b, t2a, t2b, t3a, t3b;
  logic                      useful;
  logic [CNT_W:0]            newn;
  logic signed [VALUE_W-1:0] qval;
  logic signed [LINE_W-1:0]  in_a, in_b;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;
  assign out_chan.status = out_status_r;

  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // Field views of the read word and the test operands.
  assign rd_a = rdata_r[WORD_W-1:LINE_W];
  assign rd_b = rdata_r[LINE_W-1:0];
  assign t1a  = t1_r[WORD_W-1:LINE_W];
  assign t1b  = t1_r[LINE_W-1:0];
  assign t2a  = t2_r[WORD_W-1:LINE_W];
  assign t2b  = t2_r[LINE_W-1:0];
  assign t3a  = t3_r[WORD_W-1:LINE_W];
  assign t3b  = t3_r[LINE_W-1:0];

  // The middle line is useful when (b1-b)*(a2-a) < (b-b2)*(a-a1).
  assign useful = (p0_r < prod_r);

  // Size of the table after the insert, with room for one line over the top.
  assign newn = {1'b0, k1_r} + (CNT_W+1)'(1) + {1'b0, count_r} - {1'b0, j_r};

  // Query value of the line just read.
  assign qval = prod_r[VALUE_W-1:0] + VALUE_W'(rd_b);

  // Incoming coefficients, negated in min mode.
  assign in_a = min_mode_r ? -LINE_W'(in_chan.slope)     : LINE_W'(in_chan.slope);
  assign in_b = min_mode_r ? -LINE_W'(in_chan.intercept) : LINE_W'(in_chan.intercept);

  lemq_mul u_mul (
    .clk    (clk),
    .op_x   (op_x),
    .op_y   (op_y),
    .prod_r (prod_r)
  );

  // Table storage with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.req_type == REQ_INSERT) begin
            state_nxt = ST_POS_RD;
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_Q_RD;
          end
        end
      end
      ST_POS_RD:  state_nxt = (pos_r < count_r) ? ST_POS_CHK : ST_SUCC_CHK;
      ST_POS_CHK: begin
        if (rd_a < na_r) begin
          state_nxt = ST_POS_RD;
        end else if (rd_a == na_r) begin
          state_nxt = (rd_b >= nb_r) ? ST_DONE : ST_SUCC_CHK;
        end else begin
          state_nxt = (pos_r == '0) ? ST_SUCC_CHK : ST_PREV_RD;
        end
      end
      ST_PREV_RD:  state_nxt = ST_PREV_LD;
      ST_PREV_LD:  state_nxt = ST_TST0;
      ST_SUCC_CHK: state_nxt = ((j_r + CNT_W'(1)) < count_r) ? ST_SUCC_RD0 : ST_PRED_CHK;
      ST_SUCC_RD0: state_nxt = ST_SUCC_RD1;
      ST_SUCC_RD1: state_nxt = ST_SUCC_LD;
      ST_SUCC_LD:  state_nxt = ST_TST0;
      ST_PRED_CHK: state_nxt = (k1_r >= CNT_W'(2)) ? ST_PRED_RD0 : ST_SIZE;
      ST_PRED_RD0: state_nxt = ST_PRED_RD1;
      ST_PRED_RD1: state_nxt = ST_PRED_LD;
      ST_PRED_LD:  state_nxt = ST_TST0;
      ST_TST0:     state_nxt = ST_TST1;
      ST_TST1:     state_nxt = ST_TST2;
      ST_TST2: begin
        unique case (ctx_r)
          CTX_MID:  state_nxt = useful ? ST_SUCC_CHK : ST_DONE;
          CTX_SUCC: state_nxt = useful ? ST_PRED_CHK : ST_SUCC_CHK;
          CTX_PRED: state_nxt = useful ? ST_SIZE : ST_PRED_CHK;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_SIZE: begin
        if (newn > (CNT_W+1)'(MAX_LINES)) begin
          state_nxt = ST_DONE;
        end else if ((count_r == j_r) || ((k1_r + CNT_W'(1)) == j_r)) begin
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_CPY_RD;
        end
      end
      ST_CPY_RD: state_nxt = ST_CPY_WR;
      ST_CPY_WR: begin
        if (asc_r) begin
          state_nxt = ((ci_r + CNT_W'(1)) == cnt_r) ? ST_PUT : ST_CPY_RD;
        end else begin
          state_nxt = (ci_r == '0) ? ST_PUT : ST_CPY_RD;
        end
      end
      ST_PUT:   state_nxt = ST_DONE;
      ST_Q_RD:  state_nxt = ST_Q_MUL;
      ST_Q_MUL: state_nxt = ST_Q_ACC;
      ST_Q_ACC: state_nxt = ((pos_r + CNT_W'(1)) == count_r) ? ST_DONE : ST_Q_RD;
      ST_DONE:  state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Table addresses, write port and multiplier operands.
  always_comb begin
    rd_addr = pos_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = k1_r[IDX_W-1:0];
    wr_data = {na_r, nb_r};
    op_x    = '0;
    op_y    = '0;
    unique case (state_r)
      ST_PREV_RD:  rd_addr = IDX_W'(pos_r - CNT_W'(1));
      ST_SUCC_RD0: rd_addr = j_r[IDX_W-1:0];
      ST_SUCC_RD1: rd_addr = IDX_W'(j_r + CNT_W'(1));
      ST_PRED_RD0: rd_addr = IDX_W'(k1_r - CNT_W'(2));
      ST_PRED_RD1: rd_addr = IDX_W'(k1_r - CNT_W'(1));
      ST_CPY_RD:   rd_addr = IDX_W'(j_r + ci_r);
      ST_CPY_WR: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(dst_r + ci_r);
        wr_data = rdata_r;
      end
      ST_PUT: wr_en = 1'b1;
      ST_TST0: begin
        op_x = DIFF_W'(t1b) - DIFF_W'(t2b);
        op_y = DIFF_W'(t3a) - DIFF_W'(t2a);
      end
      ST_TST1: begin
        op_x = DIFF_W'(t2b) - DIFF_W'(t3b);
        op_y = DIFF_W'(t2a) - DIFF_W'(t1a);
      end
      ST_Q_MUL: begin
        op_x = DIFF_W'(rd_a);
        op_y = DIFF_W'(x_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) begin
        min_mode_r <= cfg_chan.min_mode;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PUT) begin
        count_r <= newn_r;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        na_r         <= in_a;
        nb_r         <= in_b;
        x_r          <= in_chan.x_point;
        pos_r        <= '0;
        res_value_r  <= '0;
        res_status_r <= (in_chan.req_type == REQ_QUERY) ? STAT_EMPTY : STAT_OK;
      end
      ST_POS_RD: begin
        j_r <= pos_r;
      end
      ST_POS_CHK: begin
        t2_r  <= {na_r, nb_r};
        t3_r  <= rdata_r;
        ctx_r <= CTX_MID;
        if (rd_a < na_r) begin
          pos_r <= pos_r + CNT_W'(1);
        end else if (rd_a == na_r) begin
          j_r <= pos_r + CNT_W'(1);
        end else begin
          j_r <= pos_r;
        end
      end
      ST_PREV_LD: begin
        t1_r <= rdata_r;
      end
      ST_SUCC_CHK: begin
        k1_r <= pos_r;
      end
      ST_SUCC_RD1: begin
        t1_r <= {na_r, nb_r};
        t2_r <= rdata_r;
      end
      ST_SUCC_LD: begin
        t3_r  <= rdata_r;
        ctx_r <= CTX_SUCC;
      end
      ST_PRED_RD1: begin
        t1_r <= rdata_r;
      end
      ST_PRED_LD: begin
        t2_r  <= rdata_r;
        t3_r  <= {na_r, nb_r};
        ctx_r <= CTX_PRED;
      end
      ST_TST1: begin
        p0_r <= prod_r;
      end
      ST_TST2: begin
        if (!useful) begin
          if (ctx_r == CTX_SUCC) begin
            j_r <= j_r + CNT_W'(1);
          end else if (ctx_r == CTX_PRED) begin
            k1_r <= k1_r - CNT_W'(1);
          end
        end
      end
      ST_SIZE: begin
        newn_r <= CNT_W'(newn);
        cnt_r  <= count_r - j_r;
        dst_r  <= k1_r + CNT_W'(1);
        asc_r  <= (k1_r + CNT_W'(1)) < j_r;
        ci_r   <= ((k1_r + CNT_W'(1)) < j_r) ? '0 : (count_r - j_r - CNT_W'(1));
        if (newn > (CNT_W+1)'(MAX_LINES)) begin
          res_status_r <= STAT_FULL;
        end
      end
      ST_CPY_WR: begin
        ci_r <= asc_r ? (ci_r + CNT_W'(1)) : (ci_r - CNT_W'(1));
      end
      ST_Q_ACC: begin
        if ((pos_r == '0) || (qval > best_r)) begin
          best_r <= qval;
        end
        pos_r <= pos_r + CNT_W'(1);
        if ((pos_r + CNT_W'(1)) == count_r) begin
          res_status_r <= STAT_OK;
          if ((pos_r == '0) || (qval > best_r)) begin
            res_value_r <= min_mode_r ? -qval : qval;
          end else begin
            res_value_r <= min_mode_r ? -best_r : best_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
